>>> hdl/assert_macros.svh
// Assertion macros used by cr3_checker.sv.
// Expects signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cr3_pkg.sv
// Shared types and constants for the 3x3 Cramer solver.
// No dependencies.
`timescale 1ns / 1ps
package cr3_pkg;
  localparam int ELEM_W     = 16;
  localparam int NUM_ELEMS  = 12;
  localparam int IN_W       = ELEM_W * NUM_ELEMS;
  localparam int DET_W      = 49;
  localparam int MAG_W      = 48;
  localparam int Q_W        = 32;
  localparam int OUT_W      = 3 * Q_W;
  localparam int USER_W     = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam int USER_SOLVED = 0;
  localparam int USER_SAT    = 1;

  typedef logic signed [DET_W-1:0] det_t;

  // One classified system: main determinant and the column-replaced ones.
  typedef struct packed {
    logic solved;
    det_t den;
    det_t num0;
    det_t num1;
    det_t num2;
  } sys_t;
endpackage

>>> hdl/cr3_front.sv
// Front end: accepts beats, forms the four determinants, classifies singular.
// Depends on cr3_pkg. Holds the threshold register and the queue credit count.
`timescale 1ns / 1ps
module cr3_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cr3_pkg::IN_W-1:0]      s_tdata,
  input  logic                          cfg_we,
  input  logic [cr3_pkg::MAG_W-1:0]     cfg_wdata,
  input  logic                          pop,
  output logic                          push,
  output cr3_pkg::sys_t                 push_data
);
  logic [cr3_pkg::MAG_W-1:0] min_det_magnitude;
  logic [cr3_pkg::CNT_W-1:0] pend;
  logic                      acc;

  logic signed [15:0] e [4][9];

  logic                      v1, v2, v3;
  logic signed [15:0]        top1 [4][3];
  logic signed [31:0]        pr1  [4][6];
  cr3_pkg::det_t             t2   [4][3];
  cr3_pkg::det_t             det3 [4];

  logic signed [32:0]        minor [4][3];
  logic [cr3_pkg::MAG_W-1:0] mag_a;
  logic                      singular;

  assign s_tready = pend < cr3_pkg::CNT_W'(cr3_pkg::FIFO_DEPTH);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[0][k] = s_tdata[16*k +: 16];
    end
    for (int d = 1; d < 4; d++) begin
      for (int k = 0; k < 9; k++) begin
        e[d][k] = e[0][k];
      end
      e[d][d-1] = s_tdata[144 +: 16];
      e[d][d+2] = s_tdata[160 +: 16];
      e[d][d+5] = s_tdata[176 +: 16];
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      minor[d][0] = 33'(pr1[d][0]) - 33'(pr1[d][1]);
      minor[d][1] = 33'(pr1[d][2]) - 33'(pr1[d][3]);
      minor[d][2] = 33'(pr1[d][4]) - 33'(pr1[d][5]);
    end
  end

  assign mag_a    = det3[0][cr3_pkg::DET_W-1] ? cr3_pkg::MAG_W'(-det3[0])
                                              : cr3_pkg::MAG_W'(det3[0]);
  assign singular = (det3[0] == '0) || (mag_a < min_det_magnitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_det_magnitude <= cr3_pkg::MAG_W'(1);
      pend              <= '0;
      v1                <= 1'b0;
      v2                <= 1'b0;
      v3                <= 1'b0;
      push              <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_det_magnitude <= cfg_wdata;
      end
      pend <= pend + cr3_pkg::CNT_W'(acc) - cr3_pkg::CNT_W'(pop);
      v1   <= acc;
      v2   <= v1;
      v3   <= v2;
      push <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 4; d++) begin
      top1[d][0] <= e[d][0];
      top1[d][1] <= e[d][1];
      top1[d][2] <= e[d][2];
      pr1[d][0]  <= e[d][4] * e[d][8];
      pr1[d][1]  <= e[d][5] * e[d][7];
      pr1[d][2]  <= e[d][3] * e[d][8];
      pr1[d][3]  <= e[d][5] * e[d][6];
      pr1[d][4]  <= e[d][3] * e[d][7];
      pr1[d][5]  <= e[d][4] * e[d][6];
      for (int c = 0; c < 3; c++) begin
        t2[d][c] <= top1[d][c] * minor[d][c];
      end
      det3[d] <= t2[d][0] - t2[d][1] + t2[d][2];
    end
    push_data.solved <= !singular;
    push_data.den    <= det3[0];
    push_data.num0   <= det3[1];
    push_data.num1   <= det3[2];
    push_data.num2   <= det3[3];
  end
endmodule

>>> hdl/cr3_fifo.sv
// Short register queue between front and back ends.
// Depends on cr3_pkg. Never overflows: the front end holds a credit count.
`timescale 1ns / 1ps
module cr3_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cr3_pkg::sys_t push_data,
  input  logic          pop,
  output logic          empty,
  output cr3_pkg::sys_t rd_data
);
  cr3_pkg::sys_t             q [cr3_pkg::FIFO_DEPTH];
  logic [cr3_pkg::PTR_W-1:0] wr_ptr;
  logic [cr3_pkg::PTR_W-1:0] rd_ptr;
  logic [cr3_pkg::CNT_W-1:0] count;

  assign empty   = (count == '0);
  assign rd_data = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cr3_pkg::CNT_W'(push) - cr3_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end
endmodule

>>> hdl/cr3_back.sv
// Back end: pipelined restoring division of the three numerators by the
// main determinant, one quotient bit per stage, then saturation and output.
// Depends on cr3_pkg.
`timescale 1ns / 1ps
module cr3_back #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  cr3_pkg::sys_t                rd_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cr3_pkg::OUT_W-1:0]    m_tdata,
  output logic [cr3_pkg::USER_W-1:0]   m_tuser
);
  localparam int NW    = cr3_pkg::MAG_W + OUT_FRAC_BITS;
  localparam int RW    = cr3_pkg::MAG_W + 1;
  localparam int CW    = cr3_pkg::MAG_W + cr3_pkg::Q_W + 1;
  localparam int NSTG  = cr3_pkg::Q_W + 1;

  typedef struct packed {
    logic                    neg;
    logic                    ovf;
    logic [NW-1:0]           n;
    logic [RW-1:0]           rem;
    logic [cr3_pkg::Q_W-1:0] q;
  } lane_t;

  typedef struct packed {
    logic                      solved;
    logic [cr3_pkg::MAG_W-1:0] dmag;
    lane_t [2:0]               ln;
  } stg_t;

  stg_t  st  [NSTG];
  stg_t  nx  [NSTG];
  logic  vld [NSTG];
  logic  en;

  logic [cr3_pkg::Q_W-1:0] res [3];
  logic                    sat [3];

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !empty;

  always_comb begin
    cr3_pkg::det_t             num [3];
    logic [cr3_pkg::MAG_W-1:0] nmag;
    num[0] = rd_data.num0;
    num[1] = rd_data.num1;
    num[2] = rd_data.num2;
    nx[0].solved = rd_data.solved;
    nx[0].dmag   = rd_data.den[cr3_pkg::DET_W-1] ? cr3_pkg::MAG_W'(-rd_data.den)
                                                 : cr3_pkg::MAG_W'(rd_data.den);
    for (int i = 0; i < 3; i++) begin
      nmag = num[i][cr3_pkg::DET_W-1] ? cr3_pkg::MAG_W'(-num[i])
                                      : cr3_pkg::MAG_W'(num[i]);
      nx[0].ln[i].neg = num[i][cr3_pkg::DET_W-1] ^ rd_data.den[cr3_pkg::DET_W-1];
      nx[0].ln[i].n   = NW'(nmag) << OUT_FRAC_BITS;
      nx[0].ln[i].ovf = (CW'(nmag) << OUT_FRAC_BITS) >= (CW'(nx[0].dmag) << cr3_pkg::Q_W);
      nx[0].ln[i].rem = RW'(nx[0].ln[i].n >> cr3_pkg::Q_W);
      nx[0].ln[i].q   = '0;
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    localparam int B = cr3_pkg::Q_W - k;
    always_comb begin
      logic [RW-1:0] sh;
      nx[k] = st[k-1];
      for (int i = 0; i < 3; i++) begin
        sh = {st[k-1].ln[i].rem[RW-2:0], st[k-1].ln[i].n[B]};
        if (sh >= RW'(st[k-1].dmag)) begin
          nx[k].ln[i].rem  = sh - RW'(st[k-1].dmag);
          nx[k].ln[i].q[B] = 1'b1;
        end else begin
          nx[k].ln[i].rem = sh;
        end
      end
    end
  end

  always_comb begin
    lane_t l;
    for (int i = 0; i < 3; i++) begin
      l      = st[NSTG-1].ln[i];
      sat[i] = l.ovf || (l.neg ? (l.q[cr3_pkg::Q_W-1] && (|l.q[cr3_pkg::Q_W-2:0]))
                               : l.q[cr3_pkg::Q_W-1]);
      if (sat[i]) begin
        res[i] = l.neg ? {1'b1, {(cr3_pkg::Q_W-1){1'b0}}} : {1'b0, {(cr3_pkg::Q_W-1){1'b1}}};
      end else begin
        res[i] = l.neg ? -l.q : l.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        vld[k] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
      for (int k = 1; k < NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
      m_tvalid <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        st[k] <= nx[k];
      end
      if (st[NSTG-1].solved) begin
        m_tdata <= {res[2], res[1], res[0]};
        m_tuser[cr3_pkg::USER_SOLVED] <= 1'b1;
        m_tuser[cr3_pkg::USER_SAT]    <= sat[0] || sat[1] || sat[2];
      end else begin
        m_tdata <= '0;
        m_tuser <= '0;
      end
    end
  end
endmodule

>>> hdl/cramer_3x3_linear_solver.sv
// Channel   Dir  Payload (low bits first)
// s_*       in   tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22 rhs0 rhs1 rhs2
// m_*       out  tdata: sol0 sol1 sol2; tuser: solved saturated
// cfg_*     in   wdata: min_det_magnitude
// One beat per cycle sustained while output beats are taken. Beats pass the
// determinant pipeline, the queue, 33 division stages and 1 output register.
// The back end stalls as a whole while the output beat is not taken; the
// front end stops taking beats when the 8-entry queue credit is spent.
// Reset (rst, synchronous) clears valids and sets the threshold to 1.
`timescale 1ns / 1ps
module cramer_3x3_linear_solver #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cr3_pkg::IN_W-1:0]    s_tdata,  // m00..m22, rhs0..rhs2
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cr3_pkg::OUT_W-1:0]   m_tdata,  // sol0, sol1, sol2
  output logic [cr3_pkg::USER_W-1:0]  m_tuser,  // solved, saturated
  input  logic                        cfg_we,
  input  logic [cr3_pkg::MAG_W-1:0]   cfg_wdata
);
  logic          push, pop, empty;
  cr3_pkg::sys_t push_data, rd_data;

  cr3_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .cfg_we, .cfg_wdata,
    .pop, .push, .push_data
  );

  cr3_fifo u_fifo (
    .clk, .rst, .push, .push_data, .pop, .empty, .rd_data
  );

  cr3_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk, .rst, .empty, .rd_data, .pop, .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );
endmodule

>>> hdl/cr3_checker.sv
// Port-level checks for the solver output channel, bound to the top level.
// Depends on cr3_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cr3_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [cr3_pkg::OUT_W-1:0]   m_tdata,
  input logic [cr3_pkg::USER_W-1:0]  m_tuser
);
  `AST_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output beat dropped")
  `AST_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")
  `AST_NOW(a_singular_zero, m_tvalid && !m_tuser[cr3_pkg::USER_SOLVED], (m_tdata == '0) && !m_tuser[cr3_pkg::USER_SAT], "singular beat not zero")
  `AST_NOW(a_sat_clip, m_tvalid && m_tuser[cr3_pkg::USER_SAT], m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 || m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 || m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000, "saturated without clipped value")
endmodule

bind cramer_3x3_linear_solver cr3_checker u_chk (.*);

>>> sim/solver_checker.sv
// Checker for the 3x3 Cramer solver: watches input and output beats,
// predicts each solution and compares field by field. Depends on cr3_pkg.
`timescale 1ns / 1ps
module solver_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [cr3_pkg::IN_W-1:0]    s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [cr3_pkg::OUT_W-1:0]   m_tdata,
  input  logic [cr3_pkg::USER_W-1:0]  m_tuser,
  input  logic                        cfg_we,
  input  logic [cr3_pkg::MAG_W-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  typedef struct packed {
    logic        solved;
    logic        saturated;
    logic [31:0] sol0;
    logic [31:0] sol1;
    logic [31:0] sol2;
  } solution_t;

  localparam longint unsigned QUOT_CAP = 64'd1 << 40;

  solution_t                 solutions_due[$];
  logic [cr3_pkg::MAG_W-1:0] threshold;

  function automatic longint det3(longint a, longint b, longint c, longint d, longint e,
                                  longint f, longint g, longint h, longint i);
    return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Long division with 16 fraction bits, quotient capped.
  function automatic logic [31:0] quotient(longint num, longint den, inout logic sat);
    logic            neg;
    longint unsigned n, d, q, r, lim;
    neg = (num < 0) != (den < 0);
    n = magnitude(num);
    d = magnitude(den);
    q = n / d;
    r = n % d;
    for (int k = 0; k < 16; k++) begin
      if (q > QUOT_CAP) q = QUOT_CAP;
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (q > QUOT_CAP) q = QUOT_CAP;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic solution_t solve_system(logic [cr3_pkg::IN_W-1:0] beat,
                                             logic [cr3_pkg::MAG_W-1:0] thr);
    longint    e[12];
    longint    den;
    solution_t s;
    logic      sat;
    for (int k = 0; k < 12; k++) e[k] = longint'($signed(beat[k*16 +: 16]));
    den = det3(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    s = '0;
    sat = 1'b0;
    if (den == 0 || magnitude(den) < {16'd0, thr}) return s;
    s.solved = 1'b1;
    s.sol0 = quotient(det3(e[9], e[1], e[2], e[10], e[4], e[5], e[11], e[7], e[8]), den, sat);
    s.sol1 = quotient(det3(e[0], e[9], e[2], e[3], e[10], e[5], e[6], e[11], e[8]), den, sat);
    s.sol2 = quotient(det3(e[0], e[1], e[9], e[3], e[4], e[10], e[6], e[7], e[11]), den, sat);
    s.saturated = sat;
    return s;
  endfunction

  task automatic compare(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      threshold <= 48'd1;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (s_tvalid && s_tready) solutions_due.push_back(solve_system(s_tdata, threshold));
      if (m_tvalid && m_tready) begin
        if (solutions_due.size() == 0) begin
          $error("output beat with no expected solution");
          fail_count++;
        end else begin
          want = solutions_due.pop_front();
          compare("solved", want.solved, m_tuser[cr3_pkg::USER_SOLVED]);
          compare("saturated", want.saturated, m_tuser[cr3_pkg::USER_SAT]);
          compare("sol0", $signed(want.sol0), $signed(m_tdata[31:0]));
          compare("sol1", $signed(want.sol1), $signed(m_tdata[63:32]));
          compare("sol2", $signed(want.sol2), $signed(m_tdata[95:64]));
        end
      end
    end
    pending = solutions_due.size();
  end
endmodule

>>> sim/testbench.sv
// Top of the Cramer solver testbench: clock, reset, stimulus and verdict.
// Depends on cr3_pkg, cramer_3x3_linear_solver and solver_checker.
`timescale 1ns / 1ps
module testbench;
  localparam int LIMIT_CYCLES = 200000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [cr3_pkg::IN_W-1:0]    s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [cr3_pkg::OUT_W-1:0]   m_tdata;
  logic [cr3_pkg::USER_W-1:0]  m_tuser;
  logic                        cfg_we = 1'b0;
  logic [cr3_pkg::MAG_W-1:0]   cfg_wdata = '0;
  int                          fail_count;
  int                          pending;
  int                          send_idle = 0;
  int                          recv_idle = 0;
  int                          cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cramer_3x3_linear_solver uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  solver_checker u_checker (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] rand_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(2048)) - 1024);
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  // Random systems in one of three element ranges; some with a copied row to force singular.
  function automatic logic [cr3_pkg::IN_W-1:0] rand_system();
    logic [cr3_pkg::IN_W-1:0] b;
    int                       mode;
    mode = $urandom_range(2);
    for (int k = 0; k < 12; k++) b[k*16 +: 16] = rand_elem(mode);
    if ($urandom_range(7) == 0) b[48 +: 48] = b[0 +: 48];
    if ($urandom_range(9) == 0) b[32 +: 16] = 16'h0000;
    return b;
  endfunction

  function automatic logic [cr3_pkg::IN_W-1:0] pack_system(logic [15:0] d, logic [15:0] off,
                                                           logic [15:0] r);
    return {r, r, r, d, off, off, off, d, off, off, off, d};
  endfunction

  // Leaves tvalid high after the beat is taken; idling or drain drops it.
  task automatic send(logic [cr3_pkg::IN_W-1:0] b);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_threshold(logic [cr3_pkg::MAG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send(rand_system());
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(pack_system(16'h0100, 16'h0000, 16'h0100));
    send(pack_system(16'h7FFF, 16'h0000, 16'h8000));
    send(pack_system(16'h8000, 16'h0000, 16'h7FFF));
    send(pack_system(16'h0001, 16'h0000, 16'h7FFF));
    send(pack_system(16'h0001, 16'h0000, 16'h8000));
    send(pack_system(16'hFFFF, 16'h0000, 16'h7FFF));
    send(pack_system(16'h0000, 16'h0000, 16'h1234));
    send(pack_system(16'h0100, 16'h0100, 16'h0100));
    send({12{16'h7FFF}});
    send({12{16'h8000}});
    send({12{16'hFFFF}});
    send({16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
          16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
    send({16'h5555, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000, 16'h0000,
          16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000});
    drain();
    set_threshold('0);
    send(pack_system(16'h0000, 16'h0000, 16'h0100));
    send(pack_system(16'h0001, 16'h0000, 16'h0001));
    drain();
    set_threshold('1);
    send(pack_system(16'h7FFF, 16'h0000, 16'h0100));
    send(pack_system(16'h8000, 16'h0000, 16'h0100));
    drain();
    set_threshold(48'h1000000);
    send(pack_system(16'h0100, 16'h0000, 16'h0100));
    send(pack_system(16'h00FF, 16'h0000, 16'h0100));
    drain();
    set_threshold(48'd1);
    random_phase(220, 36, 58);
    set_threshold(48'h0000_4000_0000);
    random_phase(220, 58, 36);
    set_threshold(48'hAAAA_AAAA_AAAA);
    random_phase(30, 0, 0);
    set_threshold(48'd0);
    random_phase(160, 0, 0);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
